// ===== sv/pmcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// pmcsm_pkg: shared constants of the slot manager
// Operation and status codes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package pmcsm_pkg;
	localparam int MAX_SLOTS_DEF = 64;
	localparam int MAX_IDS_DEF   = 256;
	localparam int COST_BITS_DEF = 16;

	localparam logic [2:0] OP_READ  = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_PIN   = 3'd2;
	localparam logic [2:0] OP_UNPIN = 3'd3;
	localparam logic [2:0] OP_COST  = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_MISS     = 3'd1;
	localparam logic [2:0] ST_WINDOW   = 3'd2;
	localparam logic [2:0] ST_DISABLED = 3'd3;
	localparam logic [2:0] ST_NOVICTIM = 3'd4;

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_TIPS   = 3'd1;
	localparam logic [2:0] REG_WBEGIN = 3'd2;
	localparam logic [2:0] REG_WEND   = 3'd3;
	localparam logic [2:0] REG_SLOTS  = 3'd4;
endpackage

// ===== sv/pmcsm_ram.sv =====
// ----------------------------------------------------------------------------
// pmcsm_ram: generic RAM with one write port and one read port
// One write and one read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module pmcsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/pmcsm_scan.sv =====
// ----------------------------------------------------------------------------
// pmcsm_scan: victim search unit
// Keeps the running minimum cost over slots fed one per cycle.
// ----------------------------------------------------------------------------
module pmcsm_scan #(
	parameter int SLOT_W = 6,
	parameter int COST_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 feed,
	input  logic [SLOT_W-1:0]    slot,
	input  logic [COST_BITS-1:0] cost,
	output logic                 found,
	output logic [SLOT_W-1:0]    best
);
	logic [COST_BITS-1:0] best_cost_q;
	logic                 found_q;
	logic [SLOT_W-1:0]    best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (feed && (!found_q || cost < best_cost_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clear && feed && (!found_q || cost < best_cost_q)) begin
			best_cost_q <= cost;
			best_q <= slot;
		end
	end

	assign found = found_q;
	assign best  = best_q;
endmodule

// ===== sv/pinned_min_cost_slot_manager.sv =====
// ----------------------------------------------------------------------------
// pinned_min_cost_slot_manager: slot pool with pinning and min-cost eviction
// Maps ids onto slots; evicts the cheapest unpinned slot when full.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result shows
// for one cycle with done high and must be caught then. A command passes the
// lookup, decode and output states with busy high; done rises as busy falls.
// A write that takes a fresh slot also passes the owner read and commit states.
// A write miss with no fresh slot scans the pool (slots_in_use capped at
// MAX_SLOTS) through the slot memories, one slot a cycle, then takes the
// victim, reads its owner and commits, or goes to output if none is found.
// After reset a clearing pass (busy high) resets the id tables. Write
// configuration only while busy is low.
module pinned_min_cost_slot_manager
	import pmcsm_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int MAX_IDS   = MAX_IDS_DEF,
	parameter int COST_BITS = COST_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [7:0]  buffer_id,
	input  logic [15:0] cost_value,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic        resident,
	output logic [8:0]  buffer_index,
	output logic        evicted,
	output logic [7:0]  evicted_id,
	output logic [8:0]  pinned_count
);
	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SD = (MAX_SLOTS > 1) ? MAX_SLOTS : 2;
	localparam int IW = $clog2(MAX_IDS);
	localparam int CW = SW + 1;
	// slot entry: valid, slot; owner entry: used, id
	localparam int SE = SW + 1;
	localparam int OE = 9;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001, S_IDLE = 9'b000000010, S_LOOK = 9'b000000100,
		S_DEC   = 9'b000001000, S_SCANR = 9'b000010000, S_SCAN = 9'b000100000,
		S_OWNR  = 9'b001000000, S_COMMIT = 9'b010000000, S_OUT = 9'b100000000
	} state_t;
	state_t state_q;

	logic       en_q;
	logic [8:0] tips_q, wbeg_q, wend_q;
	logic [6:0] slots_q;
	logic [2:0] op_q;
	logic [7:0] id_q;
	logic [15:0] costin_q;
	logic [8:0] pin_total_q;
	logic [CW-1:0] fresh_q, scan_q, pool;
	logic [IW-1:0] clr_q;
	logic [MAX_SLOTS-1:0] pinned_slot_q;

	// id-indexed memories
	logic          sid_we, pin_we, cid_we;
	logic [IW-1:0] sid_wa, id_ra;
	logic [SE-1:0] sid_wd, sid_rd;
	logic          pin_wd, pin_rd;
	logic [COST_BITS-1:0] cid_wd, cid_rd;
	// slot-indexed memories
	logic          own_we, cs_we;
	logic [SW-1:0] own_wa, own_ra, cs_ra;
	logic [OE-1:0] own_wd, own_rd;
	logic [COST_BITS-1:0] cs_rd;
	logic [MAX_SLOTS-1:0] cs_init_q;

	logic [SW-1:0] pick_q;
	logic pick_valid_q;
	logic [2:0] st_q;
	logic res_q, ev_q;
	logic [8:0] idx_q;
	logic [7:0] evid_q;
	logic id_ok, found;
	logic [SW-1:0] best;
	logic scan_feed;
	logic [SW-1:0] scan_slot_s1;
	logic scan_valid_s1;

	assign id_ok = int'(id_q) < MAX_IDS;
	assign pool  = (int'(slots_q) < MAX_SLOTS) ? CW'(slots_q) : CW'(MAX_SLOTS);

	pmcsm_ram #(.WIDTH(SE), .DEPTH(MAX_IDS)) u_sid (.clk, .we(sid_we),
		.waddr(sid_wa), .wdata(sid_wd), .raddr(id_ra), .rdata(sid_rd));
	pmcsm_ram #(.WIDTH(1), .DEPTH(MAX_IDS)) u_pin (.clk, .we(pin_we),
		.waddr(sid_wa), .wdata(pin_wd), .raddr(id_ra), .rdata(pin_rd));
	pmcsm_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_IDS)) u_cid (.clk, .we(cid_we),
		.waddr(sid_wa), .wdata(cid_wd), .raddr(id_ra), .rdata(cid_rd));
	pmcsm_ram #(.WIDTH(OE), .DEPTH(SD)) u_own (.clk, .we(own_we),
		.waddr(own_wa), .wdata(own_wd), .raddr(own_ra), .rdata(own_rd));
	pmcsm_ram #(.WIDTH(COST_BITS), .DEPTH(SD)) u_cs (.clk, .we(cs_we),
		.waddr(own_wa), .wdata(cid_rd), .raddr(cs_ra), .rdata(cs_rd));

	pmcsm_scan #(.SLOT_W(SW), .COST_BITS(COST_BITS)) u_scan (.clk, .arst_n,
		.clear(state_q == S_DEC), .feed(scan_feed), .slot(scan_slot_s1),
		.cost(cs_init_q[scan_slot_s1] ? cs_rd : {COST_BITS{1'b1}}),
		.found, .best);

	always_comb begin
		id_ra  = (state_q == S_IDLE) ? IW'(buffer_id) : IW'(id_q);
		own_ra = (state_q == S_OWNR) ? pick_q : scan_q[SW-1:0];
		cs_ra  = scan_q[SW-1:0];
		// only slots that were ever written hold an owner
		scan_feed = (state_q == S_SCAN || state_q == S_OWNR) && scan_valid_s1
			&& cs_init_q[scan_slot_s1] && own_rd[OE-1]
			&& !pinned_slot_q[scan_slot_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0; tips_q <= '0; wbeg_q <= '0; wend_q <= 9'd256;
			slots_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: en_q    <= cfg_data[0];
				REG_TIPS:   tips_q  <= cfg_data;
				REG_WBEGIN: wbeg_q  <= cfg_data;
				REG_WEND:   wend_q  <= cfg_data;
				REG_SLOTS:  slots_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// memory writes are driven from the sequencer's registers
	logic [IW-1:0] evid_idx;
	assign evid_idx = IW'(own_rd[7:0]);
	always_comb begin
		sid_we = 1'b0; pin_we = 1'b0; cid_we = 1'b0; own_we = 1'b0; cs_we = 1'b0;
		sid_wa = IW'(id_q); sid_wd = {1'b1, pick_q}; pin_wd = 1'b0;
		cid_wd = COST_BITS'(costin_q); own_wa = pick_q; own_wd = {1'b1, id_q};
		case (state_q)
			S_CLEAR: begin
				sid_we = 1'b1; pin_we = 1'b1; cid_we = 1'b1;
				sid_wa = clr_q; sid_wd = '0; cid_wd = '0;
			end
			S_DEC: begin
				if (op_q == OP_PIN || op_q == OP_UNPIN) begin
					pin_we = en_q && id_ok; pin_wd = (op_q == OP_PIN);
				end
				cid_we = (op_q == OP_COST) && id_ok;
			end
			S_COMMIT: begin
				// drop the old owner's mapping before the new one is written
				if (pick_valid_q && cs_init_q[pick_q] && own_rd[OE-1]) begin
					sid_we = 1'b1; sid_wa = evid_idx; sid_wd = '0;
				end
			end
			S_OUT: begin
				if (op_q == OP_WRITE && st_q == ST_OK && !res_q &&
					!(id_q < tips_q[7:0] && tips_q != 0) && pick_valid_q) begin
					sid_we = 1'b1; own_we = 1'b1; cs_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	logic inwin;
	assign inwin = id_ok && {1'b0, id_q} >= wbeg_q && {1'b0, id_q} < wend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR; clr_q <= '0; pin_total_q <= '0; fresh_q <= '0;
			done <= 1'b0; cs_init_q <= '0; pinned_slot_q <= '0;
			pick_valid_q <= 1'b0; scan_valid_s1 <= 1'b0;
			op_q <= '0; id_q <= '0; costin_q <= '0; res_q <= 1'b0; ev_q <= 1'b0;
			evid_q <= '0; idx_q <= '0; st_q <= ST_OK; pick_q <= '0; scan_q <= '0;
			scan_slot_s1 <= '0;
			status <= ST_OK; resident <= 1'b0; buffer_index <= '0; evicted <= 1'b0;
			evicted_id <= '0; pinned_count <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(MAX_IDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					pick_valid_q <= 1'b0;
					if (start) begin
						op_q <= operation; id_q <= buffer_id; costin_q <= cost_value;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: state_q <= S_DEC;
				S_DEC: begin
					res_q <= id_ok && sid_rd[SE-1];
					ev_q <= 1'b0; evid_q <= '0; idx_q <= '0; st_q <= ST_OK;
					state_q <= S_OUT;
					case (op_q)
						OP_READ, OP_WRITE: begin
							if ({1'b0, id_q} < tips_q || !en_q) begin
								idx_q <= {1'b0, id_q};
								st_q <= en_q ? ST_OK : ST_DISABLED;
								res_q <= id_ok && sid_rd[SE-1];
							end else if (!inwin) st_q <= ST_WINDOW;
							else if (sid_rd[SE-1])
								idx_q <= wbeg_q + 9'(sid_rd[SW-1:0]);
							else if (op_q == OP_READ) st_q <= ST_MISS;
							else if (fresh_q < pool) begin
								pick_q <= SW'(pool - fresh_q - 1'b1);
								fresh_q <= fresh_q + 1'b1;
								pick_valid_q <= 1'b1;
								state_q <= S_OWNR;
							end else begin
								scan_q <= '0; scan_valid_s1 <= 1'b0;
								state_q <= S_SCAN;
							end
						end
						OP_PIN, OP_UNPIN: begin
							// keep the pin mark of the id's slot in step
							if (en_q && id_ok && sid_rd[SE-1])
								pinned_slot_q[sid_rd[SW-1:0]] <= (op_q == OP_PIN);
							if (!en_q) st_q <= ST_DISABLED;
							else if (!id_ok) st_q <= ST_WINDOW;
							else if (op_q == OP_PIN && !pin_rd)
								pin_total_q <= pin_total_q + 1'b1;
							else if (op_q == OP_UNPIN && pin_rd)
								pin_total_q <= pin_total_q - 1'b1;
						end
						OP_COST: if (!id_ok) st_q <= ST_WINDOW;
						default: ;
					endcase
				end
				S_SCAN: begin
					// address slot scan_q, feed the previous one to the unit
					scan_slot_s1 <= scan_q[SW-1:0];
					scan_valid_s1 <= scan_q < pool;
					scan_q <= scan_q + 1'b1;
					if (scan_q == pool + 1'b1) state_q <= S_SCANR;
				end
				S_SCANR: begin
					scan_valid_s1 <= 1'b0;
					if (found) begin
						pick_q <= best; pick_valid_q <= 1'b1; state_q <= S_OWNR;
					end else begin
						st_q <= ST_NOVICTIM; state_q <= S_OUT;
					end
				end
				S_OWNR: begin
					scan_valid_s1 <= 1'b0;
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (cs_init_q[pick_q] && own_rd[OE-1]) begin
						ev_q <= 1'b1; evid_q <= own_rd[7:0];
					end
					idx_q <= wbeg_q + 9'(pick_q);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (sid_we && own_we) begin
						cs_init_q[pick_q] <= 1'b1;
						pinned_slot_q[pick_q] <= pin_rd;
					end
					done <= 1'b1; status <= st_q; resident <= res_q;
					buffer_index <= idx_q; evicted <= ev_q; evicted_id <= evid_q;
					pinned_count <= pin_total_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q));
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done);
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy);
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= ST_NOVICTIM);
endmodule

// ===== sim/pmcsm_checker.sv =====
// ----------------------------------------------------------------------------
// pmcsm_checker: result predictor and comparator for the slot manager
// Mirrors configuration writes and accepted commands, predicts each result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module pmcsm_checker
	import pmcsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  operation,
	input  logic [7:0]  buffer_id,
	input  logic [15:0] cost_value,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        done,
	input  logic [2:0]  status,
	input  logic        resident,
	input  logic [8:0]  buffer_index,
	input  logic        evicted,
	input  logic [7:0]  evicted_id,
	input  logic [8:0]  pinned_count,
	output int          fail_count,
	output int          pending_count
);
	localparam int NSLOT = MAX_SLOTS_DEF;
	localparam int NID   = MAX_IDS_DEF;

	typedef struct packed {
		logic [2:0] st;
		logic       res;
		logic [8:0] idx;
		logic       ev;
		logic [7:0] ev_id;
		logic [8:0] pins;
	} slot_result_t;

	slot_result_t expected_results[$];

	logic       en_r;
	logic [8:0] tips_r, wbeg_r, wend_r;
	logic [6:0] slots_r;

	bit          has_slot[NID];
	int          slot_map[NID];
	bit          slot_busy[NSLOT];
	int          slot_owner[NSLOT];
	bit          pinned[NID];
	int          pin_sum;
	int          fresh_taken;
	logic [15:0] id_cost[NID];
	logic [15:0] slot_cost[NSLOT];

	assign pending_count = expected_results.size();

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic slot_result_t predict_slot_result(logic [2:0] op, int id,
			logic [15:0] cost);
		slot_result_t r;
		int n, s, best, old;
		bit found;
		r = '0;
		r.res = has_slot[id];
		if (op == OP_READ || op == OP_WRITE) begin
			if (id < tips_r || !en_r) begin
				r.idx = id;
				r.st = en_r ? ST_OK : ST_DISABLED;
			end else if (id < wbeg_r || id >= wend_r) begin
				r.st = ST_WINDOW;
			end else if (has_slot[id]) begin
				r.idx = wbeg_r + slot_map[id];
			end else if (op == OP_READ) begin
				r.st = ST_MISS;
			end else begin
				n = (slots_r < NSLOT) ? slots_r : NSLOT;
				found = 0;
				best = 0;
				if (fresh_taken < n) begin
					best = n - 1 - fresh_taken;
					fresh_taken++;
					found = 1;
				end else begin
					for (s = 0; s < n; s++) begin
						if (slot_busy[s] && !pinned[slot_owner[s]] &&
								(!found || slot_cost[s] < slot_cost[best])) begin
							found = 1;
							best = s;
						end
					end
				end
				if (!found) begin
					r.st = ST_NOVICTIM;
				end else begin
					if (slot_busy[best]) begin
						old = slot_owner[best];
						has_slot[old] = 0;
						r.ev = 1;
						r.ev_id = old;
					end
					slot_busy[best] = 1;
					slot_owner[best] = id;
					has_slot[id] = 1;
					slot_map[id] = best;
					slot_cost[best] = id_cost[id];
					r.idx = wbeg_r + best;
				end
			end
		end else if (op == OP_PIN || op == OP_UNPIN) begin
			if (!en_r) begin
				r.st = ST_DISABLED;
			end else begin
				if (pinned[id] && op == OP_UNPIN) pin_sum--;
				else if (!pinned[id] && op == OP_PIN) pin_sum++;
				pinned[id] = (op == OP_PIN);
			end
		end else if (op == OP_COST) begin
			id_cost[id] = cost;
		end
		r.pins = pin_sum;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_result_t got, want;
		if (!arst_n) begin
			en_r <= 0; tips_r <= 0; wbeg_r <= 0; wend_r <= 9'd256; slots_r <= 7'd64;
			for (int i = 0; i < NID; i++) begin
				has_slot[i] = 0; slot_map[i] = 0; pinned[i] = 0; id_cost[i] = '0;
			end
			for (int i = 0; i < NSLOT; i++) begin
				slot_busy[i] = 0; slot_owner[i] = 0; slot_cost[i] = '1;
			end
			pin_sum = 0;
			fresh_taken = 0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			// check the result before this edge's command can touch the state
			if (done) begin
				got = '{status, resident, buffer_index, evicted, evicted_id, pinned_count};
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result count", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (got.st != want.st) report_mismatch("status", got.st, want.st);
					if (got.res != want.res) report_mismatch("resident", got.res, want.res);
					if (got.idx != want.idx) report_mismatch("buffer_index", got.idx, want.idx);
					if (got.ev != want.ev) report_mismatch("evicted", got.ev, want.ev);
					if (got.ev_id != want.ev_id)
						report_mismatch("evicted_id", got.ev_id, want.ev_id);
					if (got.pins != want.pins)
						report_mismatch("pinned_count", got.pins, want.pins);
				end
			end
			if (start && !busy)
				expected_results.push_back(predict_slot_result(operation, buffer_id,
						cost_value));
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE: en_r <= cfg_data[0];
					REG_TIPS:   tips_r <= cfg_data;
					REG_WBEGIN: wbeg_r <= cfg_data;
					REG_WEND:   wend_r <= cfg_data;
					REG_SLOTS:  slots_r <= cfg_data[6:0];
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== sim/pinned_min_cost_slot_manager_tb.sv =====
// ----------------------------------------------------------------------------
// pinned_min_cost_slot_manager_tb: regression of the slot manager
// Drives directed and random commands through several register settings,
// with random start gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module pinned_min_cost_slot_manager_tb;
	import pmcsm_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic [2:0]  operation = '0;
	logic [7:0]  buffer_id = '0;
	logic [15:0] cost_value = '0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;
	logic        busy, done, resident, evicted;
	logic [2:0]  status;
	logic [8:0]  buffer_index, pinned_count;
	logic [7:0]  evicted_id;
	int          fail_count, pending_count;
	int          cycle_count = 0;
	int          gap_pct = 16;
	int          sent = 0;

	localparam int CYCLE_LIMIT = 1000000;

	always #5 clk = ~clk;

	pinned_min_cost_slot_manager dut (.*);
	pmcsm_checker checker_i (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input int value);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= value;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// start stays high after a transfer; a gap or a drain drops it
	task automatic issue_command(input logic [2:0] op, input int id, input int cost);
		while ($urandom_range(99) < gap_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1; operation <= op; buffer_id <= id; cost_value <= cost;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	// settle: all results in, then room for a command still in flight
	task automatic drain();
		start <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic apply_setting(input int en, input int tips, input int wb, input int we,
			input int slots);
		drain();
		write_reg(REG_ENABLE, en);
		write_reg(REG_TIPS, tips);
		write_reg(REG_WBEGIN, wb);
		write_reg(REG_WEND, we);
		write_reg(REG_SLOTS, slots);
	endtask

	// mostly writes and reads inside the window, with pins and costs mixed in
	task automatic random_phase(input int count, input int wb, input int we);
		int k, op, id;
		for (k = 0; k < count; k++) begin
			if (k > count / 2 && k < count / 2 + 150) gap_pct = 0;
			else gap_pct = 16;
			case ($urandom_range(9))
				0, 1, 2: op = OP_WRITE;
				3, 4:    op = OP_READ;
				5:       op = OP_PIN;
				6:       op = OP_UNPIN;
				7, 8:    op = OP_COST;
				default: op = $urandom_range(7);
			endcase
			if ($urandom_range(9) < 8 && we > wb) id = $urandom_range(we - 1, wb);
			else id = $urandom_range(255);
			issue_command(op, id, ($urandom_range(3) == 0) ? 16'hFFFF : $urandom_range(65535));
		end
		gap_pct = 16;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// disabled: everything maps directly, pins report disabled
		issue_command(OP_READ, 0, 0);
		issue_command(OP_WRITE, 255, 0);
		issue_command(OP_PIN, 7, 0);
		issue_command(OP_UNPIN, 7, 0);
		issue_command(OP_COST, 200, 16'hFFFF);
		issue_command(OP_COST, 201, 0);
		issue_command(3'd5, 3, 0);
		issue_command(3'd7, 255, 16'hFFFF);
		apply_setting(1, 4, 16, 40, 2);
		issue_command(OP_READ, 2, 0);      // tip
		issue_command(OP_WRITE, 50, 0);    // out of window
		issue_command(OP_READ, 20, 0);     // miss
		issue_command(OP_WRITE, 20, 0);
		issue_command(OP_WRITE, 21, 0);
		issue_command(OP_PIN, 20, 0);
		issue_command(OP_PIN, 21, 0);
		issue_command(OP_PIN, 250, 0);     // pin outside window
		issue_command(OP_WRITE, 22, 0);    // no victim
		issue_command(OP_UNPIN, 21, 0);
		issue_command(OP_WRITE, 22, 0);    // evicts 21
		issue_command(OP_READ, 20, 0);
		// grow the pool: fresh slot already occupied
		apply_setting(1, 4, 16, 40, 3);
		issue_command(OP_WRITE, 23, 0);
		issue_command(OP_WRITE, 24, 0);
		apply_setting(1, 0, 0, 256, 64);
		random_phase(400, 0, 256);
		apply_setting(1, 256, 0, 256, 64);
		random_phase(100, 0, 256);
		apply_setting(1, 8, 100, 160, 12);
		random_phase(400, 100, 160);
		apply_setting(1, 0, 200, 256, 1);
		random_phase(250, 200, 256);
		apply_setting(1, 30, 0, 0, 127);
		random_phase(100, 0, 256);
		apply_setting(0, 0, 0, 256, 64);
		random_phase(100, 0, 256);
		apply_setting(1, 0, 64, 256, 40);
		random_phase(400, 64, 256);
		drain();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
